// ===== design/ipsd_pkg.sv =====
// Shared types, constants and the sine table generator for the inverse Park / SVPWM block.
package ipsd_pkg;

    // Pipeline depth of the whole datapath (ROM read to output register).
    localparam int NSTG = 8;

    localparam logic [15:0] PERIOD_RST = 16'd7500;

    // pi in Q30 and sqrt(3)/2 in Q16
    localparam logic [63:0]        PI_Q30   = 64'd3373259426;
    localparam logic signed [17:0] SQ3H_Q16 = 18'sd56756;

    localparam int KDS_W  = 51;
    localparam int V_W    = 52;
    localparam int DUTY_W = 54;
    localparam int FRAC_W = 48;

    typedef logic signed [15:0]       trig_t;   // Q1.15 sine / cosine
    typedef logic signed [31:0]       prod_t;   // Q30 product
    typedef logic signed [32:0]       rot_t;    // Q30 stationary-frame voltage
    typedef logic signed [KDS_W-1:0]  kds_t;    // Q46
    typedef logic signed [V_W-1:0]    vref_t;   // Q46 reference voltage
    typedef logic signed [DUTY_W-1:0] duty_t;   // Q48 duty
    typedef logic [2:0]               sector_t;

    localparam duty_t ONE_Q46  = 54'sd70368744177664;   // 2^46
    localparam duty_t HALF_Q48 = 54'sd140737488355328;  // 2^47

    // Sector codes: bit0 = Va > 0, bit1 = Vb > 0, bit2 = Vc > 0
    localparam sector_t SEC_A  = 3'd1;
    localparam sector_t SEC_B  = 3'd2;
    localparam sector_t SEC_AB = 3'd3;
    localparam sector_t SEC_C  = 3'd4;
    localparam sector_t SEC_AC = 3'd5;
    localparam sector_t SEC_BC = 3'd6;

    // Quarter-wave sine entry k of a 2^tbits table, Q15, Taylor series to x^17 in Q30.
    // Elaboration-time only.
    function automatic logic [14:0] quarter_sine(input int unsigned k, input int unsigned tbits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        prod;
        logic signed [63:0] sum;
        x    = (PI_Q30 * 64'(k)) >> (tbits - 1);
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int n = 1; n <= 8; n++)
        begin
            prod = (term * x2) >> 30;
            case (n)
                1:       term = prod / 64'd6;
                2:       term = prod / 64'd20;
                3:       term = prod / 64'd42;
                4:       term = prod / 64'd72;
                5:       term = prod / 64'd110;
                6:       term = prod / 64'd156;
                7:       term = prod / 64'd210;
                default: term = prod / 64'd272;
            endcase
            if ((n % 2) == 1)
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = 0;
        sum = (sum + 64'sd16384) >>> 15;
        if (sum > 64'sd32767)
            sum = 64'sd32767;
        return sum[14:0];
    endfunction

endpackage

// ===== design/ipsd_if.sv =====
// Request channel interfaces: voltage/angle input and compare-value output.
interface ipsd_in_if;
    import ipsd_pkg::*;

    logic               valid;
    logic               ready;
    logic [15:0]        rotor_angle;
    logic signed [15:0] volt_d;
    logic signed [15:0] volt_q;

    modport source (output valid, output rotor_angle, output volt_d, output volt_q,
                    input ready);
    modport sink   (input valid, input rotor_angle, input volt_d, input volt_q,
                    output ready);
endinterface

interface ipsd_out_if;
    import ipsd_pkg::*;

    logic        valid;
    logic        ready;
    logic [15:0] compare_a;
    logic [15:0] compare_b;
    logic [15:0] compare_c;
    sector_t     sector_code;

    modport source (output valid, output compare_a, output compare_b, output compare_c,
                    output sector_code, input ready);
    modport sink   (input valid, input compare_a, input compare_b, input compare_c,
                    input sector_code, output ready);
endinterface

// ===== design/ipsd_trig.sv =====
// Sine/cosine lookup stage: quarter-wave ROM with two registered read ports.
module ipsd_trig #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        rotor_angle,
    input  logic signed [15:0] volt_d,
    input  logic signed [15:0] volt_q,
    output logic [14:0]        sin_mag,
    output logic               sin_neg,
    output logic [14:0]        cos_mag,
    output logic               cos_neg,
    output logic signed [15:0] d_out,
    output logic signed [15:0] q_out
);
    import ipsd_pkg::*;

    localparam int QB    = SINE_TABLE_BITS - 2;
    localparam int QTR_N = 1 << QB;
    localparam logic [14:0] PEAK = quarter_sine(QTR_N, SINE_TABLE_BITS);

    logic [14:0] qtab [QTR_N];

    for (genvar k = 0; k < QTR_N; k++)
    begin : g_qtab
        assign qtab[k] = quarter_sine(k, SINE_TABLE_BITS);
    end

    logic [SINE_TABLE_BITS-1:0] idx;
    logic [1:0]                 s_quad;
    logic [1:0]                 c_quad;
    logic [QB-1:0]              r;
    logic [QB-1:0]              r_mirror;
    logic [QB-1:0]              s_addr;
    logic [QB-1:0]              c_addr;
    logic                       s_peak;
    logic                       c_peak;

    logic [14:0]        sin_mag_reg;
    logic [14:0]        cos_mag_reg;
    logic               sin_neg_reg;
    logic               cos_neg_reg;
    logic signed [15:0] d_reg;
    logic signed [15:0] q_reg;

    always_comb
    begin
        idx      = rotor_angle[15 -: SINE_TABLE_BITS];
        s_quad   = idx[SINE_TABLE_BITS-1 -: 2];
        c_quad   = s_quad + 2'd1;
        r        = idx[QB-1:0];
        r_mirror = ~r + 1'b1;
        // odd quadrants run the quarter wave backward; r == 0 there is the peak
        s_addr   = s_quad[0] ? r_mirror : r;
        c_addr   = c_quad[0] ? r_mirror : r;
        s_peak   = s_quad[0] && (r == '0);
        c_peak   = c_quad[0] && (r == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_mag_reg <= s_peak ? PEAK : qtab[s_addr];
            cos_mag_reg <= c_peak ? PEAK : qtab[c_addr];
            sin_neg_reg <= s_quad[1];
            cos_neg_reg <= c_quad[1];
            d_reg       <= volt_d;
            q_reg       <= volt_q;
        end
    end

    assign sin_mag = sin_mag_reg;
    assign cos_mag = cos_mag_reg;
    assign sin_neg = sin_neg_reg;
    assign cos_neg = cos_neg_reg;
    assign d_out   = d_reg;
    assign q_out   = q_reg;

endmodule

// ===== design/ipsd_rot.sv =====
// Inverse Park rotation: four products, sum/difference, then the sqrt(3)/2 scale.
module ipsd_rot (
    input  logic               clk,
    input  logic [2:0]         en,
    input  logic [14:0]        sin_mag,
    input  logic               sin_neg,
    input  logic [14:0]        cos_mag,
    input  logic               cos_neg,
    input  logic signed [15:0] volt_d,
    input  logic signed [15:0] volt_q,
    output ipsd_pkg::rot_t     qs_out,
    output ipsd_pkg::kds_t     kds_out
);
    import ipsd_pkg::*;

    trig_t sn;
    trig_t cs;

    prod_t p_dc_reg;
    prod_t p_qs_reg;
    prod_t p_qc_reg;
    prod_t p_ds_reg;
    rot_t  ds_reg;
    rot_t  qs_reg;
    rot_t  qs3_reg;
    kds_t  kds_reg;

    always_comb
    begin
        sn = sin_neg ? -trig_t'({1'b0, sin_mag}) : trig_t'({1'b0, sin_mag});
        cs = cos_neg ? -trig_t'({1'b0, cos_mag}) : trig_t'({1'b0, cos_mag});
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p_dc_reg <= volt_d * cs;
            p_qs_reg <= volt_q * sn;
            p_qc_reg <= volt_q * cs;
            p_ds_reg <= volt_d * sn;
        end
        if (en[1])
        begin
            ds_reg <= 33'(p_dc_reg) - 33'(p_qs_reg);
            qs_reg <= 33'(p_qc_reg) + 33'(p_ds_reg);
        end
        if (en[2])
        begin
            kds_reg <= ds_reg * SQ3H_Q16;
            qs3_reg <= qs_reg;
        end
    end

    assign qs_out  = qs3_reg;
    assign kds_out = kds_reg;

endmodule

// ===== design/ipsd_duty.sv =====
// Reference voltages, sector code and the three Q48 phase duties.
module ipsd_duty (
    input  logic              clk,
    input  logic [1:0]        en,
    input  ipsd_pkg::rot_t    qs,
    input  ipsd_pkg::kds_t    kds,
    output ipsd_pkg::duty_t   duty_a,
    output ipsd_pkg::duty_t   duty_b,
    output ipsd_pkg::duty_t   duty_c,
    output ipsd_pkg::sector_t sector
);
    import ipsd_pkg::*;

    vref_t   va_next;
    vref_t   vb_next;
    vref_t   vc_next;
    vref_t   qs_half;
    sector_t code_next;

    vref_t   va_reg;
    vref_t   vb_reg;
    vref_t   vc_reg;
    sector_t code_v_reg;

    vref_t   t1;
    vref_t   t2;
    duty_t   d_first;
    duty_t   d_second;
    duty_t   d_third;
    duty_t   ta_next;
    duty_t   tb_next;
    duty_t   tc_next;

    duty_t   ta_reg;
    duty_t   tb_reg;
    duty_t   tc_reg;
    sector_t code_d_reg;

    always_comb
    begin
        qs_half   = vref_t'(qs) <<< 15;
        va_next   = vref_t'(qs) <<< 16;
        vb_next   = vref_t'(kds) - qs_half;
        vc_next   = -vref_t'(kds) - qs_half;
        code_next = {vc_next > 0, vb_next > 0, va_next > 0};
    end

    // Chained steps collapse to ONE -/+ t1 -/+ t2; the sector picks which phase gets each.
    always_comb
    begin
        t1 = '0;
        t2 = '0;
        case (code_v_reg)
            SEC_A:   begin t1 = vc_reg;  t2 = vb_reg;  end
            SEC_B:   begin t1 = vb_reg;  t2 = -va_reg; end
            SEC_AB:  begin t1 = -vc_reg; t2 = va_reg;  end
            SEC_C:   begin t1 = -va_reg; t2 = vc_reg;  end
            SEC_AC:  begin t1 = va_reg;  t2 = -vb_reg; end
            SEC_BC:  begin t1 = -vb_reg; t2 = -vc_reg; end
            default: begin t1 = '0;      t2 = '0;      end
        endcase
        d_first  = ONE_Q46 - duty_t'(t1) - duty_t'(t2);
        d_second = ONE_Q46 + duty_t'(t1) - duty_t'(t2);
        d_third  = ONE_Q46 + duty_t'(t1) + duty_t'(t2);
        case (code_v_reg)
            SEC_A:   begin tb_next = d_first; ta_next = d_second; tc_next = d_third; end
            SEC_B:   begin ta_next = d_first; tc_next = d_second; tb_next = d_third; end
            SEC_AB:  begin ta_next = d_first; tb_next = d_second; tc_next = d_third; end
            SEC_C:   begin tc_next = d_first; tb_next = d_second; ta_next = d_third; end
            SEC_AC:  begin tb_next = d_first; tc_next = d_second; ta_next = d_third; end
            SEC_BC:  begin tc_next = d_first; ta_next = d_second; tb_next = d_third; end
            default: begin ta_next = HALF_Q48; tb_next = HALF_Q48; tc_next = HALF_Q48; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            va_reg     <= va_next;
            vb_reg     <= vb_next;
            vc_reg     <= vc_next;
            code_v_reg <= code_next;
        end
        if (en[1])
        begin
            ta_reg     <= ta_next;
            tb_reg     <= tb_next;
            tc_reg     <= tc_next;
            code_d_reg <= code_v_reg;
        end
    end

    assign duty_a = ta_reg;
    assign duty_b = tb_reg;
    assign duty_c = tc_reg;
    assign sector = code_d_reg;

endmodule

// ===== design/ipsd_scale.sv =====
// One phase: saturate a Q48 duty and scale it by the PWM period (split multiply).
module ipsd_scale (
    input  logic            clk,
    input  logic [1:0]      en,
    input  ipsd_pkg::duty_t duty,
    input  logic [15:0]     period,
    output logic [15:0]     compare
);
    import ipsd_pkg::*;

    logic              zero_next;
    logic              full_next;
    logic [FRAC_W-1:0] frac;

    logic              zero_reg;
    logic              full_reg;
    logic [31:0]       ph_reg;
    logic [47:0]       pl_reg;

    logic [63:0]       prod;
    logic [15:0]       cmp_next;
    logic [15:0]       cmp_reg;

    always_comb
    begin
        frac      = duty[FRAC_W-1:0];
        zero_next = duty[DUTY_W-1] || (duty == '0);
        full_next = !duty[DUTY_W-1] && (|duty[DUTY_W-2:FRAC_W]);
    end

    always_comb
    begin
        prod = {ph_reg, 32'd0} + 64'(pl_reg);
        if (zero_reg)
            cmp_next = '0;
        else if (full_reg)
            cmp_next = period;
        else
            cmp_next = prod[63:48];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            zero_reg <= zero_next;
            full_reg <= full_next;
            ph_reg   <= frac[47:32] * period;
            pl_reg   <= frac[31:0] * period;
        end
        if (en[1])
        begin
            cmp_reg <= cmp_next;
        end
    end

    assign compare = cmp_reg;

endmodule

// ===== design/inverse_park_svpwm_duty.sv =====
// Top level: inverse Park transform and SVPWM compare-value pipeline.
//
//  channel   dir  handshake      payload
//  volt      in   valid/ready    rotor_angle[16] volt_d[16 s] volt_q[16 s]
//  duty      out  valid/ready    compare_a/b/c[16] sector_code[3]
//  cfg       in   cfg_we         cfg_wdata[16] -> pwm_period
//
//  One request per cycle sustained while duty.ready holds; the stage chain is
//  ROM read, 16x16 products, rotate add, sqrt(3)/2 multiply, reference
//  voltages, duties, split period multiply, output register.
//  Reset clears the stage valid bits and loads pwm_period with 7500.
//  A stage holds only while its successor is full and held; empty slots
//  are filled, so input ready stays high while a result waits on duty.ready
//  and drops only once all eight stages hold a request.
module inverse_park_svpwm_duty #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    ipsd_in_if.sink     volt,
    ipsd_out_if.source  duty,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import ipsd_pkg::*;

    logic [15:0]     pwm_period_reg;
    logic [NSTG-1:0] stg_vld_reg;
    logic [NSTG-1:0] stg_vld_next;
    logic [NSTG-1:0] en;

    // trig -> rot
    logic [14:0]        sin_mag;
    logic [14:0]        cos_mag;
    logic               sin_neg;
    logic               cos_neg;
    logic signed [15:0] d_s0;
    logic signed [15:0] q_s0;

    // rot -> duty
    rot_t qs_s3;
    kds_t kds_s3;

    // duty -> scale
    duty_t   duty_a;
    duty_t   duty_b;
    duty_t   duty_c;
    sector_t sector_s5;
    sector_t sector_s6_reg;
    sector_t sector_s7_reg;

    // Per-stage advance: a stage moves when empty or when the next one moves.
    always_comb
    begin
        en[NSTG-1] = !stg_vld_reg[NSTG-1] || duty.ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            en[i] = !stg_vld_reg[i] || en[i+1];
        end
        stg_vld_next[0] = en[0] ? volt.valid : stg_vld_reg[0];
        for (int i = 1; i < NSTG; i++)
        begin
            stg_vld_next[i] = en[i] ? stg_vld_reg[i-1] : stg_vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_vld_reg    <= '0;
            pwm_period_reg <= PERIOD_RST;
        end
        else
        begin
            stg_vld_reg <= stg_vld_next;
            if (cfg_we)
                pwm_period_reg <= cfg_wdata;
        end
    end

    // Stage 0: sine/cosine ROM
    ipsd_trig #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_trig (
        .clk         (clk),
        .en          (en[0]),
        .rotor_angle (volt.rotor_angle),
        .volt_d      (volt.volt_d),
        .volt_q      (volt.volt_q),
        .sin_mag     (sin_mag),
        .sin_neg     (sin_neg),
        .cos_mag     (cos_mag),
        .cos_neg     (cos_neg),
        .d_out       (d_s0),
        .q_out       (q_s0)
    );

    // Stages 1..3: rotation into the stationary frame
    ipsd_rot u_rot (
        .clk     (clk),
        .en      (en[3:1]),
        .sin_mag (sin_mag),
        .sin_neg (sin_neg),
        .cos_mag (cos_mag),
        .cos_neg (cos_neg),
        .volt_d  (d_s0),
        .volt_q  (q_s0),
        .qs_out  (qs_s3),
        .kds_out (kds_s3)
    );

    // Stages 4..5: references, sector, duties
    ipsd_duty u_duty (
        .clk    (clk),
        .en     (en[5:4]),
        .qs     (qs_s3),
        .kds    (kds_s3),
        .duty_a (duty_a),
        .duty_b (duty_b),
        .duty_c (duty_c),
        .sector (sector_s5)
    );

    // Stages 6..7: saturation and period scaling, one lane per phase
    ipsd_scale u_scale_a (
        .clk     (clk),
        .en      (en[7:6]),
        .duty    (duty_a),
        .period  (pwm_period_reg),
        .compare (duty.compare_a)
    );

    ipsd_scale u_scale_b (
        .clk     (clk),
        .en      (en[7:6]),
        .duty    (duty_b),
        .period  (pwm_period_reg),
        .compare (duty.compare_b)
    );

    ipsd_scale u_scale_c (
        .clk     (clk),
        .en      (en[7:6]),
        .duty    (duty_c),
        .period  (pwm_period_reg),
        .compare (duty.compare_c)
    );

    always_ff @(posedge clk)
    begin
        if (en[6])
            sector_s6_reg <= sector_s5;
        if (en[7])
            sector_s7_reg <= sector_s6_reg;
    end

    assign volt.ready       = en[0];
    assign duty.valid       = stg_vld_reg[NSTG-1];
    assign duty.sector_code = sector_s7_reg;

    // An accepted request always occupies the first stage next cycle.
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (volt.valid && volt.ready) |=> stg_vld_reg[0])
        else $error("accepted request not captured in stage 0");

    // Compare values never exceed the period.
    a_cmp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        duty.valid |-> (duty.compare_a <= pwm_period_reg) && (duty.compare_b <= pwm_period_reg)
                       && (duty.compare_c <= pwm_period_reg))
        else $error("compare value above pwm_period");

    // Null sectors give half duty on all phases.
    a_null_sector: assert property (@(posedge clk) disable iff (!rst_n)
        (duty.valid && (duty.sector_code == 3'd0 || duty.sector_code == 3'd7))
        |-> (duty.compare_a == (pwm_period_reg >> 1)) && (duty.compare_b == duty.compare_a)
            && (duty.compare_c == duty.compare_a))
        else $error("null sector without half duty");

endmodule

// ===== tb/ipsd_duty_check.sv =====
// Duty channel checker: predicts compare values and sector codes and compares them.
module ipsd_duty_check #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    ipsd_in_if          volt,
    ipsd_out_if         duty,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);
    import ipsd_pkg::*;

    localparam int unsigned TBL_N = 1 << SINE_TABLE_BITS;
    localparam int unsigned QTR_N = 1 << (SINE_TABLE_BITS - 2);
    localparam logic signed [63:0] FULL_Q48 = 64'sd281474976710656;

    typedef struct packed {
        logic [15:0] compare_a;
        logic [15:0] compare_b;
        logic [15:0] compare_c;
        sector_t     sector_code;
    } duty_exp_t;

    logic signed [15:0] sine_lut [TBL_N];
    logic [15:0]        period = PERIOD_RST;
    duty_exp_t          duty_expect [$];
    int                 errors = 0;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // Quarter-wave sine, Taylor series in Q30, rounded to Q15.
    function automatic logic signed [15:0] qwave_sine(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        x    = (PI_Q30 * 64'(k)) >> (SINE_TABLE_BITS - 1);
        x2   = (x * x) >> 30;
        term = x;
        acc  = signed'(x);
        for (int n = 1; n <= 8; n++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc = acc - signed'(term);
            else
                acc = acc + signed'(term);
        end
        if (acc < 0)
            acc = 0;
        acc = (acc + 64'sd16384) >>> 15;
        if (acc > 64'sd32767)
            acc = 64'sd32767;
        return acc[15:0];
    endfunction

    initial
    begin
        int unsigned        quad;
        int unsigned        rem;
        logic signed [15:0] mag;
        for (int unsigned k = 0; k < TBL_N; k++)
        begin
            quad = (k >> (SINE_TABLE_BITS - 2)) & 3;
            rem  = k & (QTR_N - 1);
            mag  = quad[0] ? qwave_sine(QTR_N - rem) : qwave_sine(rem);
            sine_lut[k] = quad[1] ? -mag : mag;
        end
    end

    // Q48 duty to compare value, saturated to 0..period.
    function automatic logic [15:0] duty_to_compare(input logic signed [63:0] t);
        logic [63:0] ut;
        logic [63:0] prod;
        if (t <= 0)
            return 16'd0;
        if (t >= FULL_Q48)
            return period;
        ut   = t;
        prod = ut * {48'd0, period};
        return prod[63:48];
    endfunction

    function automatic duty_exp_t svpwm_compare(input logic [15:0] ang,
                                                input logic signed [15:0] vd,
                                                input logic signed [15:0] vq);
        int unsigned        idx;
        logic signed [63:0] sn, cs, d, q, ds, qs, va, vb, vc;
        logic signed [63:0] t1, t2, ta, tb, tc;
        sector_t            code;
        duty_exp_t          res;
        idx = ang >> (16 - SINE_TABLE_BITS);
        sn  = sine_lut[idx];
        cs  = sine_lut[(idx + QTR_N) % TBL_N];
        d   = vd;
        q   = vq;
        ds  = d * cs - q * sn;
        qs  = q * cs + d * sn;
        va  = qs * 64'sd65536;
        vb  = -qs * 64'sd32768 + ds * SQ3H_Q16;
        vc  = -qs * 64'sd32768 - ds * SQ3H_Q16;
        code = {vc > 0, vb > 0, va > 0};
        case (code)
            SEC_A:
            begin
                t1 = vc;  t2 = vb;
                tb = ONE_Q46 - t1 - t2; ta = tb + 2 * t1; tc = ta + 2 * t2;
            end
            SEC_B:
            begin
                t1 = vb;  t2 = -va;
                ta = ONE_Q46 - t1 - t2; tc = ta + 2 * t1; tb = tc + 2 * t2;
            end
            SEC_AB:
            begin
                t1 = -vc; t2 = va;
                ta = ONE_Q46 - t1 - t2; tb = ta + 2 * t1; tc = tb + 2 * t2;
            end
            SEC_C:
            begin
                t1 = -va; t2 = vc;
                tc = ONE_Q46 - t1 - t2; tb = tc + 2 * t1; ta = tb + 2 * t2;
            end
            SEC_AC:
            begin
                t1 = va;  t2 = -vb;
                tb = ONE_Q46 - t1 - t2; tc = tb + 2 * t1; ta = tc + 2 * t2;
            end
            SEC_BC:
            begin
                t1 = -vb; t2 = -vc;
                tc = ONE_Q46 - t1 - t2; ta = tc + 2 * t1; tb = ta + 2 * t2;
            end
            default:
            begin
                ta = HALF_Q48; tb = HALF_Q48; tc = HALF_Q48;
            end
        endcase
        res.compare_a   = duty_to_compare(ta);
        res.compare_b   = duty_to_compare(tb);
        res.compare_c   = duty_to_compare(tc);
        res.sector_code = code;
        return res;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        duty_exp_t want;
        if (!rst_n)
        begin
            period = PERIOD_RST;
            duty_expect.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
                period = cfg_wdata;
            if (volt.valid && volt.ready)
                duty_expect.push_back(svpwm_compare(volt.rotor_angle, volt.volt_d,
                                                    volt.volt_q));
            if (duty.valid && duty.ready)
            begin
                if (duty_expect.size() == 0)
                begin
                    $error("duty request with no prediction pending");
                    errors++;
                end
                else
                begin
                    want = duty_expect.pop_front();
                    check_field("compare_a", want.compare_a, duty.compare_a);
                    check_field("compare_b", want.compare_b, duty.compare_b);
                    check_field("compare_c", want.compare_c, duty.compare_c);
                    check_field("sector_code", want.sector_code, duty.sector_code);
                end
            end
            pending <= duty_expect.size();
        end
        fail_count <= errors;
    end

endmodule

// ===== tb/tb_inverse_park_svpwm_duty.sv =====
// Top of the inverse Park / SVPWM duty testbench: clock, reset, stimulus and verdict.
module tb_inverse_park_svpwm_duty;
    import ipsd_pkg::*;

    localparam int TBL_BITS     = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 200;
    // drain wait, sized from the pipeline depth, before touching the period register
    localparam int DRAIN_CYCLES = 2 * NSTG + 4;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    int fail_count;
    int pending;
    int cycles = 0;

    // Idle knobs, percent of cycles; owned by the stimulus process.
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_en      = 1'b0;
    bit hold_done    = 1'b0;

    ipsd_in_if  volt_if ();
    ipsd_out_if duty_if ();

    inverse_park_svpwm_duty #(
        .SINE_TABLE_BITS (TBL_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .volt      (volt_if),
        .duty      (duty_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    ipsd_duty_check #(
        .SINE_TABLE_BITS (TBL_BITS)
    ) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .volt       (volt_if),
        .duty       (duty_if),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Duty receiver. Random back-pressure per rx_stall_pct; once hold_en is
    // seen, ready stays low for a long stretch so the pipeline fills and the
    // volt channel has to stall.
    initial
    begin
        forever
        begin
            if (hold_en && !hold_done)
            begin
                duty_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            duty_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            @(posedge clk);
        end
    end

    // Offer one volt request, with random idle cycles ahead of it, and hold
    // it until accepted. valid is left high so back-to-back requests never
    // see a low/high pair in one step.
    task automatic send_req(input logic [15:0] ang,
                            input logic signed [15:0] vd,
                            input logic signed [15:0] vq);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            volt_if.valid <= 1'b0;
            @(posedge clk);
        end
        volt_if.valid       <= 1'b1;
        volt_if.rotor_angle <= ang;
        volt_if.volt_d      <= vd;
        volt_if.volt_q      <= vq;
        do
            @(posedge clk);
        while (!volt_if.ready);
    endtask

    // Voltage mix: mostly mid-range, some full-scale (saturating duties),
    // some tiny values near the zero vector.
    function automatic logic signed [15:0] rand_volt();
        int unsigned kind;
        kind = $urandom_range(9);
        if (kind < 6)
            return 16'(int'($urandom_range(48000)) - 24000);
        else if (kind < 8)
            return 16'($urandom);
        else
            return 16'(int'($urandom_range(16)) - 8);
    endfunction

    task automatic random_reqs(input int count);
        for (int i = 0; i < count; i++)
            send_req(16'($urandom), rand_volt(), rand_volt());
    endtask

    // Drop valid, let every predicted result drain plus some slack, then
    // load a new period and switch the idle knobs for the next phase.
    task automatic reprogram(input logic [15:0] new_period, input int tx_pct,
                             input int rx_pct);
        volt_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= new_period;
        @(posedge clk);
        cfg_we       <= 1'b0;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= 16'd0;
        volt_if.valid       <= 1'b0;
        volt_if.rotor_angle <= 16'd0;
        volt_if.volt_d      <= 16'sd0;
        volt_if.volt_q      <= 16'sd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests at the reset period, no idling.
        send_req(16'h0000, 16'sd0, 16'sd0);          // zero vector: all duties half
        send_req(16'h9abc, 16'sd0, 16'sd0);
        send_req(16'h0000, 16'sh7fff, 16'sd0);
        send_req(16'h4000, 16'sh8000, 16'sd0);
        send_req(16'h8000, 16'sd0, 16'sh7fff);
        send_req(16'hc000, 16'sd0, 16'sh8000);
        send_req(16'hffff, 16'sh7fff, 16'sh7fff);    // full scale: saturated duties
        send_req(16'h2000, 16'sh8000, 16'sh8000);
        send_req(16'h6000, 16'sh7fff, 16'sh8000);
        send_req(16'h003f, 16'sd1, 16'sd0);          // below one table step
        send_req(16'h0040, 16'sd0, -16'sd1);
        send_req(16'h4000, 16'sd16384, 16'sd0);
        // one request next to each of the six sector boundaries
        for (int k = 0; k < 6; k++)
            send_req(16'(k * 16'h2aab + 16'h1555), 16'sd0, 16'sd16384);
        random_reqs(150);

        reprogram(16'hffff, 85, 0);                  // largest period, sender idling
        random_reqs(150);

        reprogram(16'd1, 0, 85);                     // smallest legal period, receiver stalling
        random_reqs(150);

        reprogram(16'($urandom_range(1, 65535)), 15, 15);
        random_reqs(150);

        reprogram(16'd0, 0, 0);                      // zero period: every compare is 0
        random_reqs(50);

        // Long receiver hold-off with the sender pushing every cycle.
        reprogram(16'($urandom_range(1, 65535)), 0, 15);
        hold_en = 1'b1;
        random_reqs(200);

        volt_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
